// File: rtl/ilid_pkg.sv
package ilid_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 7;
  localparam int LEN_W      = 7;
  localparam int IN_DATA_W  = ((POS_W + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VALUE_BITS + LEN_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [IDX_W-1:0]      pos;
    logic [VALUE_BITS-1:0] value;
    logic [IDX_W-1:0]      rd_pos;
  } cell_cmd_t;

endpackage

// File: rtl/ilid_cell.sv
module ilid_cell (
  input  logic                            clk,
  input  ilid_pkg::cell_cmd_t             cmd,
  input  logic [ilid_pkg::IDX_W-1:0]      idx,
  input  logic [ilid_pkg::VALUE_BITS-1:0] left_q,
  input  logic [ilid_pkg::VALUE_BITS-1:0] right_q,
  output logic [ilid_pkg::VALUE_BITS-1:0] q,
  output logic [ilid_pkg::VALUE_BITS-1:0] sel_q
);

  logic [ilid_pkg::VALUE_BITS-1:0] q_r;
  logic [ilid_pkg::VALUE_BITS-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (cmd.ins) begin
      if (idx == cmd.pos) begin
        q_nxt = cmd.value;
      end else if (idx > cmd.pos) begin
        q_nxt = left_q;
      end
    end else if (cmd.del) begin
      if (idx >= cmd.pos) begin
        q_nxt = right_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q     = q_r;
  assign sel_q = (idx == cmd.rd_pos) ? q_r : '0;

endmodule

// File: rtl/indexed_list_insert_delete.sv
// Channel  Dir  tdata (low bit up)                         tuser
// in       in   position[6:0], new_value[38:7], pad        req_type[1:0]
// out      out  read_value[31:0], length[38:32], pad       status[1:0]
//
// One request a cycle while the output is not stalled; the result appears in the cycle after its beat is taken.
// Each entry sits in its own cell; inserts and deletes shift all cells at or
// above the position in the same cycle, reads pick one cell through an OR tree.
// Reset clears the length and the result valid; entry contents are left as is.
// A stalled result blocks a new beat only when the output register is full.
module indexed_list_insert_delete (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ilid_pkg::IN_DATA_W-1:0]   in_tdata,  // position, new_value
  input  logic [1:0]                       in_tuser,  // req_type
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ilid_pkg::OUT_DATA_W-1:0]  out_tdata, // read_value, length
  output logic [1:0]                       out_tuser  // status
);

  logic                            in_fire;
  logic [ilid_pkg::POS_W-1:0]      pos;
  logic [ilid_pkg::VALUE_BITS-1:0] new_value;
  ilid_pkg::req_t                  req;
  ilid_pkg::cell_cmd_t             cmd;
  logic [ilid_pkg::CNT_W-1:0]      count_r;
  logic [ilid_pkg::CNT_W-1:0]      count_nxt;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic [ilid_pkg::VALUE_BITS-1:0] rd_value_r;
  logic [ilid_pkg::VALUE_BITS-1:0] rd_value_nxt;
  ilid_pkg::status_t               status_r;
  ilid_pkg::status_t               status_nxt;
  logic [ilid_pkg::VALUE_BITS-1:0] rd_or;
  logic [ilid_pkg::POS_W-1:0]      ins_pos;
  logic                            pos_ok;
  logic [ilid_pkg::VALUE_BITS-1:0] cell_q   [ilid_pkg::CAPACITY];
  logic [ilid_pkg::VALUE_BITS-1:0] cell_sel [ilid_pkg::CAPACITY];
  logic [ilid_pkg::VALUE_BITS-1:0] cell_l   [ilid_pkg::CAPACITY];
  logic [ilid_pkg::VALUE_BITS-1:0] cell_rt  [ilid_pkg::CAPACITY];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign pos       = in_tdata[ilid_pkg::POS_W-1:0];
  assign new_value = in_tdata[ilid_pkg::POS_W +: ilid_pkg::VALUE_BITS];
  assign req       = ilid_pkg::req_t'(in_tuser);
  assign pos_ok    = (ilid_pkg::CNT_W'(pos) < count_r);
  assign ins_pos   = (ilid_pkg::CNT_W'(pos) > count_r)
                     ? ilid_pkg::POS_W'(count_r) : pos;

  always_comb begin
    cmd.ins    = 1'b0;
    cmd.del    = 1'b0;
    cmd.pos    = pos[ilid_pkg::IDX_W-1:0];
    cmd.value  = new_value;
    cmd.rd_pos = pos[ilid_pkg::IDX_W-1:0];
    count_nxt  = count_r;
    status_nxt = ilid_pkg::ST_OK;
    rd_value_nxt = '0;
    unique case (req)
      ilid_pkg::REQ_INSERT: begin
        if (count_r == ilid_pkg::CNT_W'(ilid_pkg::CAPACITY)) begin
          status_nxt = ilid_pkg::ST_FULL;
        end else begin
          cmd.ins   = in_fire;
          cmd.pos   = ins_pos[ilid_pkg::IDX_W-1:0];
          count_nxt = count_r + ilid_pkg::CNT_W'(1);
        end
      end
      ilid_pkg::REQ_DELETE: begin
        if (!pos_ok) begin
          status_nxt = ilid_pkg::ST_RANGE;
        end else begin
          cmd.del   = in_fire;
          count_nxt = count_r - ilid_pkg::CNT_W'(1);
        end
      end
      ilid_pkg::REQ_READ: begin
        if (!pos_ok) begin
          status_nxt = ilid_pkg::ST_RANGE;
        end else begin
          rd_value_nxt = rd_or;
        end
      end
      default: begin
        status_nxt = ilid_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < ilid_pkg::CAPACITY; i++) begin
      rd_or = rd_or | cell_sel[i];
    end
  end

  always_comb begin
    for (int i = 0; i < ilid_pkg::CAPACITY; i++) begin
      cell_l[i]  = (i == 0) ? '0 : cell_q[(i == 0) ? 0 : i - 1];
      cell_rt[i] = (i == ilid_pkg::CAPACITY - 1) ? '0
                   : cell_q[(i == ilid_pkg::CAPACITY - 1) ? i : i + 1];
    end
  end

  for (genvar g = 0; g < ilid_pkg::CAPACITY; g++) begin : g_cell
    ilid_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .idx     (ilid_pkg::IDX_W'(g)),
      .left_q  (cell_l[g]),
      .right_q (cell_rt[g]),
      .q       (cell_q[g]),
      .sel_q   (cell_sel[g])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_value_r <= rd_value_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ilid_pkg::OUT_DATA_W-ilid_pkg::VALUE_BITS-ilid_pkg::LEN_W){1'b0}},
                       ilid_pkg::LEN_W'(count_r), rd_value_r};
  assign out_tuser  = status_r;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ilid_pkg::CNT_W'(ilid_pkg::CAPACITY))
    else $error("length above capacity");

  a_read_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && req == ilid_pkg::REQ_READ |=> count_r == $past(count_r))
    else $error("read changed length");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && status_nxt == ilid_pkg::ST_FULL |=>
      count_r == ilid_pkg::CNT_W'(ilid_pkg::CAPACITY))
    else $error("full status without full list");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ilid_pkg::ST_OK |-> rd_value_r == '0)
    else $error("error result carries data");
`endif

endmodule
